[src/rat_alu_pkg.sv]
package rat_alu_pkg;

	localparam int WORD_BITS = 32;
	localparam int WIDE_BITS = 64;

	typedef enum logic [2:0] {
		CMD_LOAD = 3'd0,
		CMD_ADD  = 3'd1,
		CMD_SUB  = 3'd2,
		CMD_MUL  = 3'd3,
		CMD_DIV  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic signed [31:0] operand_num;
		logic signed [31:0] operand_den;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result_num;
		logic [30:0] result_den;
		logic [1:0]  status;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_COMB,
		S_CHECK,
		S_GCD,
		S_DIVN,
		S_DIVD,
		S_FIN,
		S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;
		logic mul_a;
		logic mul_b;
		logic combine;
		logic gcd_start;
		logic gcd_step;
		logic div_start;
		logic div_step;
		logic div_sel_den;
		logic take_num;
		logic take_den;
		logic commit;
		logic set_zero_err;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic known_cmd;
		logic den_zero;
		logic gcd_done;
		logic div_done;
	} sts_t;

endpackage

[src/rat_alu_ctrl.sv]
module rat_alu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              out_fire,
	input  rat_alu_pkg::sts_t sts,
	output rat_alu_pkg::ctl_t ctl,
	output logic              busy,
	output logic              out_valid
);

	rat_alu_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rat_alu_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		busy      = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			rat_alu_pkg::S_IDLE: begin
				busy = 1'b0;
				if (in_fire) begin
					ctl.load_in = 1'b1;
					state_d = rat_alu_pkg::S_MUL1;
				end
			end
			rat_alu_pkg::S_MUL1: begin
				ctl.mul_a = 1'b1;
				state_d = rat_alu_pkg::S_MUL2;
			end
			rat_alu_pkg::S_MUL2: begin
				ctl.mul_b = 1'b1;
				state_d = rat_alu_pkg::S_COMB;
			end
			rat_alu_pkg::S_COMB: begin
				ctl.combine = 1'b1;
				state_d = rat_alu_pkg::S_CHECK;
			end
			rat_alu_pkg::S_CHECK: begin
				if (!sts.known_cmd) begin
					state_d = rat_alu_pkg::S_OUT;
				end else if (sts.den_zero) begin
					ctl.set_zero_err = 1'b1;
					state_d = rat_alu_pkg::S_OUT;
				end else begin
					ctl.gcd_start = 1'b1;
					state_d = rat_alu_pkg::S_GCD;
				end
			end
			rat_alu_pkg::S_GCD: begin
				if (sts.gcd_done) begin
					ctl.div_start = 1'b1;
					state_d = rat_alu_pkg::S_DIVN;
				end else begin
					ctl.gcd_step = 1'b1;
				end
			end
			rat_alu_pkg::S_DIVN: begin
				if (sts.div_done) begin
					ctl.take_num = 1'b1;
					ctl.div_start = 1'b1;
					ctl.div_sel_den = 1'b1;
					state_d = rat_alu_pkg::S_DIVD;
				end else begin
					ctl.div_step = 1'b1;
				end
			end
			rat_alu_pkg::S_DIVD: begin
				if (sts.div_done) begin
					ctl.take_den = 1'b1;
					state_d = rat_alu_pkg::S_FIN;
				end else begin
					ctl.div_step = 1'b1;
				end
			end
			rat_alu_pkg::S_FIN: begin
				ctl.commit = 1'b1;
				state_d = rat_alu_pkg::S_OUT;
			end
			rat_alu_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (out_fire) begin
					state_d = rat_alu_pkg::S_IDLE;
				end
			end
			default: state_d = rat_alu_pkg::S_IDLE;
		endcase
	end

endmodule

[src/rat_alu_dp.sv]
module rat_alu_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rat_alu_pkg::in_item_t in_item,
	input  rat_alu_pkg::ctl_t     ctl,
	output rat_alu_pkg::sts_t     sts,
	output rat_alu_pkg::out_item_t out_item
);

	localparam int W = rat_alu_pkg::WORD_BITS;
	localparam int D = rat_alu_pkg::WIDE_BITS;

	logic [2:0]    cmd_q;
	logic [W-1:0]  on_q, od_q;
	logic [W-1:0]  acc_num_q, acc_den_q;
	logic [1:0]    status_q;
	logic [D-1:0]  p1_q, p2_q;
	logic [D-1:0]  nm_q, dm_q;
	logic          neg_q;
	logic [D-1:0]  ga_q, gb_q;
	logic [6:0]    gk_q;
	logic [D-1:0]  quo_q, rem_q, dvsr_q, dvnd_q;
	logic [6:0]    cnt_q;
	logic [D-1:0]  rn_q, rd_q;

	logic son, sod, sa;
	logic [W-1:0] mon, mod, ma;
	logic [W-1:0] mul_x, mul_y;
	logic [D-1:0] mul_p;
	logic         sn_c, sd_c;
	logic [D-1:0] nm_c, dm_c;
	logic         s2;
	logic         sx;
	logic [D:0]   rem_sh;
	logic [D-1:0] half;
	logic [D-1:0] g_c;

	assign son = on_q[W-1];
	assign sod = od_q[W-1];
	assign sa  = acc_num_q[W-1];
	assign mon = son ? (~on_q + 1'b1) : on_q;
	assign mod = sod ? (~od_q + 1'b1) : od_q;
	assign ma  = sa ? (~acc_num_q + 1'b1) : acc_num_q;
	assign s2  = (cmd_q == rat_alu_pkg::CMD_SUB) ? ~son : son;
	assign sx  = sa ^ sod;
	assign half = {{(D-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

	// one shared 32x32 multiplier, used in S_MUL1 and S_MUL2
	always_comb begin
		mul_x = ma;
		mul_y = mod;
		if (ctl.mul_a) begin
			case (cmd_q)
				rat_alu_pkg::CMD_MUL: begin mul_x = ma; mul_y = mon; end
				default: begin mul_x = ma; mul_y = mod; end
			endcase
		end else begin
			case (cmd_q)
				rat_alu_pkg::CMD_DIV: begin mul_x = acc_den_q; mul_y = mon; end
				rat_alu_pkg::CMD_ADD, rat_alu_pkg::CMD_SUB: begin
					mul_x = mon; mul_y = acc_den_q;
				end
				default: begin mul_x = acc_den_q; mul_y = mod; end
			endcase
		end
	end
	assign mul_p = {{(D-W){1'b0}}, mul_x} * {{(D-W){1'b0}}, mul_y};

	always_comb begin
		sn_c = 1'b0; sd_c = 1'b0; nm_c = '0; dm_c = {{(D-1){1'b0}}, 1'b1};
		case (cmd_q)
			rat_alu_pkg::CMD_LOAD: begin
				sn_c = son; nm_c = {{(D-W){1'b0}}, mon};
				sd_c = sod; dm_c = {{(D-W){1'b0}}, mod};
			end
			rat_alu_pkg::CMD_ADD, rat_alu_pkg::CMD_SUB: begin
				// p1 = ma*mod, p2 = mon*mad, dm needs mad*mod: computed directly below
				if (sx == s2) begin
					sn_c = sx; nm_c = p1_q + p2_q;
				end else if (p1_q >= p2_q) begin
					sn_c = sx; nm_c = p1_q - p2_q;
				end else begin
					sn_c = s2; nm_c = p2_q - p1_q;
				end
				sd_c = sod;
				dm_c = {{(D-W){1'b0}}, acc_den_q} * {{(D-W){1'b0}}, mod};
			end
			rat_alu_pkg::CMD_MUL: begin
				sn_c = sa ^ son; nm_c = p1_q; sd_c = sod; dm_c = p2_q;
			end
			rat_alu_pkg::CMD_DIV: begin
				sn_c = sa ^ sod; nm_c = p1_q; sd_c = son; dm_c = p2_q;
			end
			default: ;
		endcase
	end

	assign rem_sh = {rem_q, dvnd_q[D-1]};

	// gcd: the nonzero survivor, scaled back by the shared factors of two
	assign g_c = ((gb_q == '0) ? ga_q : gb_q) << gk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_num_q <= '0;
			acc_den_q <= {{(W-1){1'b0}}, 1'b1};
			status_q  <= rat_alu_pkg::ST_OK;
		end else begin
			if (ctl.load_in) begin
				status_q <= rat_alu_pkg::ST_OK;
			end
			if (ctl.set_zero_err) begin
				status_q <= rat_alu_pkg::ST_ZERO_DEN;
			end
			if (ctl.commit) begin
				if (rd_q > half - 1'b1 || (neg_q ? rn_q > half : rn_q > half - 1'b1)) begin
					status_q <= rat_alu_pkg::ST_OVERFLOW;
				end else begin
					acc_num_q <= neg_q ? (~rn_q[W-1:0] + 1'b1) : rn_q[W-1:0];
					acc_den_q <= rd_q[W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q <= in_item.cmd;
			on_q  <= in_item.operand_num;
			od_q  <= in_item.operand_den;
		end
		if (ctl.mul_a) p1_q <= mul_p;
		if (ctl.mul_b) p2_q <= mul_p;
		if (ctl.combine) begin
			nm_q  <= nm_c;
			dm_q  <= dm_c;
			neg_q <= (sn_c != sd_c) && (nm_c != '0);
		end
		if (ctl.gcd_start) begin
			ga_q <= nm_q;
			gb_q <= dm_q;
			gk_q <= '0;
		end else if (ctl.gcd_step) begin
			// one binary gcd step: each one drops at least one bit
			if (!ga_q[0] && !gb_q[0]) begin
				ga_q <= ga_q >> 1;
				gb_q <= gb_q >> 1;
				gk_q <= gk_q + 1'b1;
			end else if (!ga_q[0]) begin
				ga_q <= ga_q >> 1;
			end else if (!gb_q[0]) begin
				gb_q <= gb_q >> 1;
			end else if (ga_q >= gb_q) begin
				ga_q <= (ga_q - gb_q) >> 1;
			end else begin
				gb_q <= (gb_q - ga_q) >> 1;
			end
		end
		if (ctl.div_start) begin
			dvnd_q <= ctl.div_sel_den ? dm_q : nm_q;
			dvsr_q <= g_c;
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
		end else if (ctl.div_step) begin
			if (rem_sh >= {1'b0, dvsr_q}) begin
				rem_q <= D'(rem_sh - {1'b0, dvsr_q});
				quo_q <= {quo_q[D-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[D-1:0];
				quo_q <= {quo_q[D-2:0], 1'b0};
			end
			dvnd_q <= {dvnd_q[D-2:0], 1'b0};
			cnt_q  <= cnt_q + 1'b1;
		end
		if (ctl.take_num) rn_q <= quo_q;
		if (ctl.take_den) rd_q <= quo_q;
	end

	assign sts.known_cmd = (cmd_q <= rat_alu_pkg::CMD_DIV);
	assign sts.den_zero  = (dm_q == '0);
	assign sts.gcd_done  = (gb_q == '0) || (ga_q == '0);
	assign sts.div_done  = (cnt_q == 7'(D));

	assign out_item.result_num = acc_num_q;
	assign out_item.result_den = acc_den_q[W-2:0];
	assign out_item.status     = status_q;

endmodule

[src/rational_accumulator_alu_unit.sv]
// Rational accumulator ALU.
// Input channel in_valid/in_ready carries one command (load, add, subtract,
// multiply, divide) with a signed fraction operand. Output channel
// out_valid/out_ready returns one result per command: the accumulator
// after the step, reduced, with a positive denominator, and a status
// (ok, zero denominator, overflow). On error the accumulator holds.
// One item at a time: a transfer in starts the sequence, and the next
// transfer in is taken only after the result transfer out.
// Sequence: multiplies in S_MUL1 and S_MUL2, combine, check, a binary gcd
// loop of one step per cycle (at most 128 steps on 64-bit values) whose
// done test ends it, then two restoring divides sharing one divider
// (numerator, then denominator), and a commit. Only the gcd loop varies
// in length with the operands. A zero denominator or unknown command
// skips gcd and divides and goes from check straight to the output.
// A new command is taken only after the result transfer and idle.
// Reset clears the accumulator to 0/1 and the controller to idle.
// When the receiver stalls, the result holds on out and in_ready stays low.
module rational_accumulator_alu_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  rat_alu_pkg::in_item_t  in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output rat_alu_pkg::out_item_t out_data
);

	rat_alu_pkg::ctl_t ctl;
	rat_alu_pkg::sts_t sts;
	logic busy;
	logic in_fire, out_fire;

	// accept only while idle
	assign in_ready = ~busy;
	assign in_fire  = in_valid & in_ready;
	assign out_fire = out_valid & out_ready;

	rat_alu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_fire (out_fire),
		.sts      (sts),
		.ctl      (ctl),
		.busy     (busy),
		.out_valid(out_valid)
	);

	rat_alu_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_data),
		.ctl     (ctl),
		.sts     (sts),
		.out_item(out_data)
	);

	// never accept while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken with result pending");

	// denominator of the held accumulator stays positive
	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.result_den != '0) else $error("zero denominator held");

	// a result follows a transfer in only after work
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !out_valid) else $error("result without work");

endmodule
